/* sv/plsm_pkg.sv */
// ----------------------------------------------------------------------------
// plsm_pkg
// Shared types and codes of the pinned LRU page-slot manager.
// ----------------------------------------------------------------------------
package plsm_pkg;

   // request commands
   localparam logic CMD_GET     = 1'b0;
   localparam logic CMD_RELEASE = 1'b1;

   // response status codes
   localparam logic [2:0] RSP_HIT      = 3'd0;
   localparam logic [2:0] RSP_MISS     = 3'd1;
   localparam logic [2:0] RSP_NO_SLOT  = 3'd2;
   localparam logic [2:0] RSP_RELEASED = 3'd3;
   localparam logic [2:0] RSP_NOT_FND  = 3'd4;

   localparam logic [7:0] PIN_MAX = 8'hFF;

   // one slot of the table
   typedef struct packed {
      logic [31:0] page;
      logic [31:0] stamp;
      logic [7:0]  pin;
      logic        dirty;
   } slot_entry_type;

   // what the scan has found so far
   typedef struct packed {
      logic           hit_found;
      slot_entry_type hit_entry;
      logic           vic_found;
      logic           vic_valid;
      logic [31:0]    vic_page;
   } scan_result_type;

endpackage

/* sv/plsm_slot_store.sv */
// ----------------------------------------------------------------------------
// plsm_slot_store
// Slot table: one memory of entries with registered read, plus valid flops.
// An entry that is not valid reads with zero stamp, pin count and dirty.
// ----------------------------------------------------------------------------
module plsm_slot_store
   import plsm_pkg::*;
#(
   parameter int SLOTS = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] rd_idx,
   output slot_entry_type         rd_entry,
   output logic                   rd_valid,
   input  logic                   wr_en,
   input  logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] wr_idx,
   input  slot_entry_type         wr_entry
);

   slot_entry_type             mem [SLOTS];
   slot_entry_type             rd_q_ff;
   logic [SLOTS-1:0]           valid_ff;
   logic [SLOTS-1:0]           valid_in;

   // memory port: one write, one registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx] <= wr_entry;
      end
      rd_q_ff <= mem[rd_idx];
   end

   // every write leaves the slot occupied
   always_comb begin
      valid_in = valid_ff;
      if (wr_en) begin
         valid_in[wr_idx] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // mask entries that were never written to their reset value
   assign rd_valid       = valid_ff[rd_idx];
   assign rd_entry.page  = rd_q_ff.page;
   assign rd_entry.stamp = rd_valid ? rd_q_ff.stamp : 32'd0;
   assign rd_entry.pin   = rd_valid ? rd_q_ff.pin : 8'd0;
   assign rd_entry.dirty = rd_valid & rd_q_ff.dirty;

endmodule

/* sv/plsm_scan.sv */
// ----------------------------------------------------------------------------
// plsm_scan
// Shared compare unit: looks at one slot per step, tracks the first address
// match and the oldest unpinned slot (lowest index on ties).
// ----------------------------------------------------------------------------
module plsm_scan
   import plsm_pkg::*;
#(
   parameter int SLOTS = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic                   eval,
   input  logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] idx,
   input  slot_entry_type         entry,
   input  logic                   entry_valid,
   input  logic [31:0]            addr,
   output scan_result_type        result,
   output logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] hit_idx,
   output logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] vic_idx
);

   localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   logic           hit_found_ff, hit_found_in;
   logic           vic_found_ff, vic_found_in;
   slot_entry_type hit_entry_ff;
   logic [SW-1:0]  hit_idx_ff;
   logic [SW-1:0]  vic_idx_ff;
   logic [31:0]    oldest_ff;
   logic           vic_valid_ff;
   logic [31:0]    vic_page_ff;
   logic           take_hit;
   logic           take_vic;

   // the two compares of this step
   assign take_hit = eval && !hit_found_ff && entry_valid && (entry.page == addr);
   assign take_vic = eval && (entry.pin == 8'd0) &&
                     (!vic_found_ff || (entry.stamp < oldest_ff));

   assign hit_found_in = start ? 1'b0 : (hit_found_ff | take_hit);
   assign vic_found_in = start ? 1'b0 : (vic_found_ff | take_vic);

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_found_ff <= 1'b0;
         vic_found_ff <= 1'b0;
      end else begin
         hit_found_ff <= hit_found_in;
         vic_found_ff <= vic_found_in;
      end
   end

   // captured payload of the match and the victim
   always_ff @(posedge clock) begin
      if (take_hit) begin
         hit_entry_ff <= entry;
         hit_idx_ff   <= idx;
      end
      if (take_vic) begin
         oldest_ff    <= entry.stamp;
         vic_idx_ff   <= idx;
         vic_valid_ff <= entry_valid;
         vic_page_ff  <= entry.page;
      end
   end

   assign result.hit_found = hit_found_ff;
   assign result.hit_entry = hit_entry_ff;
   assign result.vic_found = vic_found_ff;
   assign result.vic_valid = vic_valid_ff;
   assign result.vic_page  = vic_page_ff;
   assign hit_idx          = hit_idx_ff;
   assign vic_idx          = vic_idx_ff;

endmodule

/* sv/pinned_lru_page_slot_manager_core.sv */
// ----------------------------------------------------------------------------
// pinned_lru_page_slot_manager_core
// Buffer-pool slot manager with pin counts and LRU replacement of unpinned
// slots; one slot is examined per step by a shared compare unit.
//
//   channel | direction | handshake          | fields
//   req     | in        | req_valid/ready    | command, page_addr, now
//   rsp     | out       | rsp_valid/ready    | status, slot, write_back,
//           |           |                    | write_back_addr, fill
//
// After a request is accepted, the scan visits each slot in a read state and a
// compare state, set by the single read port of the slot memory, then a resolve
// state, which waits while the response register is full. req_ready returns
// after the resolve, so a new request is not taken until the last is resolved.
// Reset clears the valid flags at once; there is no clearing pass. The response
// register holds a result until it is taken; a new request may be scanned
// meanwhile, and its table update waits until the response register is free.
// ----------------------------------------------------------------------------
module pinned_lru_page_slot_manager_core
   import plsm_pkg::*;
#(
   parameter int SLOTS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_command,
   input  logic [31:0] req_page_addr,
   input  logic [31:0] req_now,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic [2:0]  rsp_slot,
   output logic        rsp_write_back,
   output logic [31:0] rsp_write_back_addr,
   output logic        rsp_fill
);

   localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_READ = 4'b0010,
      ST_EVAL = 4'b0100,
      ST_DONE = 4'b1000
   } state_type;

   state_type       state_ff, state_in;
   logic [SW-1:0]   idx_ff, idx_in;
   logic            cmd_ff;
   logic [31:0]     addr_ff;
   logic [31:0]     now_ff;
   logic            accept;
   logic            out_free;
   logic            last_slot;

   logic            rsp_valid_ff, rsp_valid_in;
   logic [2:0]      status_ff, status_in;
   logic [2:0]      slot_ff, slot_in;
   logic            wb_ff, wb_in;
   logic [31:0]     wba_ff, wba_in;
   logic            fill_ff, fill_in;

   slot_entry_type  rd_entry;
   logic            rd_valid;
   logic            wr_en;
   logic [SW-1:0]   wr_idx;
   slot_entry_type  wr_entry;
   scan_result_type scan_res;
   logic [SW-1:0]   hit_idx;
   logic [SW-1:0]   vic_idx;
   logic [SW+2:0]   hit_idx_ext;
   logic [SW+2:0]   vic_idx_ext;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign last_slot = (idx_ff == SW'(SLOTS - 1));

   // slot index widened or cut to the 3-bit response field
   assign hit_idx_ext = {3'b000, hit_idx};
   assign vic_idx_ext = {3'b000, vic_idx};

   plsm_slot_store #(
      .SLOTS(SLOTS)
   ) u_store (
      .clock   (clock),
      .reset   (reset),
      .rd_idx  (idx_ff),
      .rd_entry(rd_entry),
      .rd_valid(rd_valid),
      .wr_en   (wr_en),
      .wr_idx  (wr_idx),
      .wr_entry(wr_entry)
   );

   plsm_scan #(
      .SLOTS(SLOTS)
   ) u_scan (
      .clock      (clock),
      .reset      (reset),
      .start      (accept),
      .eval       (state_ff == ST_EVAL),
      .idx        (idx_ff),
      .entry      (rd_entry),
      .entry_valid(rd_valid),
      .addr       (addr_ff),
      .result     (scan_res),
      .hit_idx    (hit_idx),
      .vic_idx    (vic_idx)
   );

   // sequencer
   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_READ;
               idx_in   = '0;
            end
         end
         ST_READ: begin
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            if (last_slot) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_READ;
               idx_in   = idx_ff + SW'(1);
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

   // request capture
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff  <= req_command;
         addr_ff <= req_page_addr;
         now_ff  <= req_now;
      end
   end

   // resolve: table update and response
   always_comb begin
      wr_en     = 1'b0;
      wr_idx    = hit_idx;
      wr_entry  = scan_res.hit_entry;
      status_in = status_ff;
      slot_in   = slot_ff;
      wb_in     = wb_ff;
      wba_in    = wba_ff;
      fill_in   = fill_ff;
      if ((state_ff == ST_DONE) && out_free) begin
         slot_in = 3'd0;
         wb_in   = 1'b0;
         wba_in  = 32'd0;
         fill_in = 1'b0;
         if (cmd_ff == CMD_GET) begin
            if (scan_res.hit_found) begin
               status_in      = RSP_HIT;
               slot_in        = hit_idx_ext[2:0];
               wr_en          = 1'b1;
               wr_entry.stamp = now_ff;
               if (scan_res.hit_entry.pin != PIN_MAX) begin
                  wr_entry.pin = scan_res.hit_entry.pin + 8'd1;
               end
            end else if (scan_res.vic_found) begin
               status_in      = RSP_MISS;
               slot_in        = vic_idx_ext[2:0];
               wb_in          = scan_res.vic_valid;
               wba_in         = scan_res.vic_valid ? scan_res.vic_page : 32'd0;
               fill_in        = 1'b1;
               wr_en          = 1'b1;
               wr_idx         = vic_idx;
               wr_entry.page  = addr_ff;
               wr_entry.stamp = now_ff;
               wr_entry.pin   = 8'd1;
               wr_entry.dirty = 1'b1;
            end else begin
               status_in = RSP_NO_SLOT;
            end
         end else begin
            if (scan_res.hit_found) begin
               status_in      = RSP_RELEASED;
               slot_in        = hit_idx_ext[2:0];
               wb_in          = scan_res.hit_entry.dirty;
               wba_in         = scan_res.hit_entry.dirty ? addr_ff : 32'd0;
               wr_en          = 1'b1;
               wr_entry.dirty = 1'b0;
               if (scan_res.hit_entry.pin != 8'd0) begin
                  wr_entry.pin = scan_res.hit_entry.pin - 8'd1;
               end
            end else begin
               status_in = RSP_NOT_FND;
            end
         end
      end
   end

   // response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if ((state_ff == ST_DONE) && out_free) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      slot_ff   <= slot_in;
      wb_ff     <= wb_in;
      wba_ff    <= wba_in;
      fill_ff   <= fill_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = status_ff;
   assign rsp_slot            = slot_ff;
   assign rsp_write_back      = wb_ff;
   assign rsp_write_back_addr = wba_ff;
   assign rsp_fill            = fill_ff;

`ifndef NO_ASSERTIONS
   // a fill is only requested for a miss
   a_fill_on_miss: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_fill) |-> (rsp_status == RSP_MISS))
      else $error("fill flagged on a non-miss response");

   // no write-back address without a write-back
   a_wba_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_write_back) |-> (rsp_write_back_addr == 32'd0))
      else $error("write-back address set without write-back");

   // the scan index stays inside the table
   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> (idx_ff <= SW'(SLOTS - 1)))
      else $error("scan index out of range");

   // the table is only written when a response is produced
   a_write_with_rsp: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> rsp_valid)
      else $error("table written without a response");
`endif

endmodule
